@@ design/erm_pkg.sv @@
// ============================================================================
// erm_pkg
// Shared constants and elaboration-time sine table math for the Euler
// rotation matrix unit.
// ============================================================================
`default_nettype none

package erm_pkg;

   localparam int unsigned ANGLE_BITS_DEFAULT = 12;
   localparam int unsigned FRAC_BITS_DEFAULT  = 14;
   localparam int unsigned ENTRY_WIDTH        = 16;

   // Series arithmetic for the quarter-wave table, Q2.62 unsigned
   localparam int unsigned QBITS         = 62;
   localparam logic [63:0] HALF_PI_Q62   = 64'h6487ED5110B4611A;
   localparam int unsigned SERIES_TERMS  = 14;

   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[QBITS+63:QBITS];
   endfunction

   // Divide a series term by (2n)(2n+1)
   function automatic logic [63:0] series_div(input logic [63:0] term, input int unsigned n);
      logic [63:0] res;
      unique case (n)
         1:       res = term / 64'd6;
         2:       res = term / 64'd20;
         3:       res = term / 64'd42;
         4:       res = term / 64'd72;
         5:       res = term / 64'd110;
         6:       res = term / 64'd156;
         7:       res = term / 64'd210;
         8:       res = term / 64'd272;
         9:       res = term / 64'd342;
         10:      res = term / 64'd420;
         11:      res = term / 64'd506;
         12:      res = term / 64'd600;
         13:      res = term / 64'd702;
         14:      res = term / 64'd812;
         default: res = term;
      endcase
      return res;
   endfunction

   // round(sin(k * pi/2 / quarter) * 2^frac_bits), evaluated only for constants
   function automatic logic [63:0] quarter_sine(input int unsigned angle_bits,
                                                input int unsigned frac_bits,
                                                input logic [63:0]  k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      x    = (HALF_PI_Q62 >> (angle_bits - 2)) * k;
      x2   = mul_q62(x, x);
      term = x;
      sum  = x;
      for (int unsigned n = 1; n <= SERIES_TERMS; n++) begin
         term = series_div(mul_q62(term, x2), n);
         if (n[0]) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      sum = (sum + (64'd1 << (QBITS - 1 - frac_bits))) >> (QBITS - frac_bits);
      return sum;
   endfunction

endpackage

`default_nettype wire

@@ design/erm_sine_rom.sv @@
// ============================================================================
// erm_sine_rom
// Quarter-wave sine table with two registered read ports.
// ============================================================================
`default_nettype none

module erm_sine_rom #(
   parameter int unsigned ANGLE_BITS = erm_pkg::ANGLE_BITS_DEFAULT,
   parameter int unsigned FRAC_BITS  = erm_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic [ANGLE_BITS-2:0] rd_addr_a,
   input  logic [ANGLE_BITS-2:0] rd_addr_b,
   output logic [FRAC_BITS:0]    rd_data_a,
   output logic [FRAC_BITS:0]    rd_data_b
);
   import erm_pkg::*;

   localparam int unsigned QUARTER = 1 << (ANGLE_BITS - 2);
   localparam int unsigned DEPTH   = QUARTER + 1;
   localparam int unsigned DATA_W  = FRAC_BITS + 1;

   logic [DATA_W-1:0] rom_word [DEPTH];
   logic [DATA_W-1:0] rd_data_a_ff;
   logic [DATA_W-1:0] rd_data_b_ff;

   for (genvar i = 0; i < DEPTH; i++) begin : g_rom
      assign rom_word[i] = DATA_W'(quarter_sine(ANGLE_BITS, FRAC_BITS, 64'(i)));
   end

   always_ff @(posedge clock) begin
      rd_data_a_ff <= rom_word[rd_addr_a];
      rd_data_b_ff <= rom_word[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

`default_nettype wire

@@ design/erm_trig.sv @@
// ============================================================================
// erm_trig
// Sine and cosine of the three negated angles: table read, then sign fold.
// ============================================================================
`default_nettype none

module erm_trig #(
   parameter int unsigned ANGLE_BITS = erm_pkg::ANGLE_BITS_DEFAULT,
   parameter int unsigned FRAC_BITS  = erm_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [ANGLE_BITS-1:0]       angle_x,
   input  logic [ANGLE_BITS-1:0]       angle_y,
   input  logic [ANGLE_BITS-1:0]       angle_z,
   output logic                        out_valid,
   output logic signed [FRAC_BITS+1:0] sin_x,
   output logic signed [FRAC_BITS+1:0] cos_x,
   output logic signed [FRAC_BITS+1:0] sin_y,
   output logic signed [FRAC_BITS+1:0] cos_y,
   output logic signed [FRAC_BITS+1:0] sin_z,
   output logic signed [FRAC_BITS+1:0] cos_z
);
   import erm_pkg::*;

   localparam int unsigned QUARTER = 1 << (ANGLE_BITS - 2);
   localparam int unsigned ADDR_W  = ANGLE_BITS - 1;
   localparam int unsigned VAL_W   = FRAC_BITS + 2;

   logic [ANGLE_BITS-1:0]   angle [3];
   logic                    a_valid_ff, a_valid_in;
   logic                    b_valid_ff, b_valid_in;
   logic [2:0]              a_sin_neg_ff, a_sin_neg_in;
   logic [2:0]              a_cos_neg_ff, a_cos_neg_in;
   logic [FRAC_BITS:0]      sin_mag [3];
   logic [FRAC_BITS:0]      cos_mag [3];
   logic signed [VAL_W-1:0] b_sin_ff [3];
   logic signed [VAL_W-1:0] b_cos_ff [3];
   logic signed [VAL_W-1:0] b_sin_in [3];
   logic signed [VAL_W-1:0] b_cos_in [3];

   assign angle[0] = angle_x;
   assign angle[1] = angle_y;
   assign angle[2] = angle_z;

   for (genvar i = 0; i < 3; i++) begin : g_axis
      logic [ANGLE_BITS-1:0] neg_angle;
      logic [1:0]            quadrant;
      logic [ADDR_W-1:0]     addr_fwd;
      logic [ADDR_W-1:0]     addr_rev;
      logic [ADDR_W-1:0]     sin_addr;
      logic [ADDR_W-1:0]     cos_addr;

      // Negate modulo a full turn, split into quadrant and offset
      assign neg_angle = ANGLE_BITS'(0) - angle[i];
      assign quadrant  = neg_angle[ANGLE_BITS-1 -: 2];
      assign addr_fwd  = {1'b0, neg_angle[ANGLE_BITS-3:0]};
      assign addr_rev  = ADDR_W'(QUARTER) - addr_fwd;
      // Odd quadrants mirror the sine; cosine is the sine a quadrant ahead
      assign sin_addr  = quadrant[0] ? addr_rev : addr_fwd;
      assign cos_addr  = quadrant[0] ? addr_fwd : addr_rev;
      assign a_sin_neg_in[i] = quadrant[1];
      assign a_cos_neg_in[i] = quadrant[1] ^ quadrant[0];

      erm_sine_rom #(
         .ANGLE_BITS (ANGLE_BITS),
         .FRAC_BITS  (FRAC_BITS)
      ) u_rom (
         .clock     (clock),
         .rd_addr_a (sin_addr),
         .rd_addr_b (cos_addr),
         .rd_data_a (sin_mag[i]),
         .rd_data_b (cos_mag[i])
      );

      assign b_sin_in[i] = a_sin_neg_ff[i] ? -$signed(VAL_W'(sin_mag[i]))
                                           :  $signed(VAL_W'(sin_mag[i]));
      assign b_cos_in[i] = a_cos_neg_ff[i] ? -$signed(VAL_W'(cos_mag[i]))
                                           :  $signed(VAL_W'(cos_mag[i]));
   end

   assign a_valid_in = in_valid;
   assign b_valid_in = a_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_sin_neg_ff <= a_sin_neg_in;
      a_cos_neg_ff <= a_cos_neg_in;
      b_sin_ff     <= b_sin_in;
      b_cos_ff     <= b_cos_in;
   end

   assign out_valid = b_valid_ff;
   assign sin_x     = b_sin_ff[0];
   assign cos_x     = b_cos_ff[0];
   assign sin_y     = b_sin_ff[1];
   assign cos_y     = b_cos_ff[1];
   assign sin_z     = b_sin_ff[2];
   assign cos_z     = b_cos_ff[2];

endmodule

`default_nettype wire

@@ design/erm_combine.sv @@
// ============================================================================
// erm_combine
// Matrix entries from sines and cosines: pair products, triple products,
// then sums with saturation.
// ============================================================================
`default_nettype none

module erm_combine #(
   parameter int unsigned FRAC_BITS = erm_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  logic signed [FRAC_BITS+1:0]        sin_x,
   input  logic signed [FRAC_BITS+1:0]        cos_x,
   input  logic signed [FRAC_BITS+1:0]        sin_y,
   input  logic signed [FRAC_BITS+1:0]        cos_y,
   input  logic signed [FRAC_BITS+1:0]        sin_z,
   input  logic signed [FRAC_BITS+1:0]        cos_z,
   output logic                               out_valid,
   output logic [erm_pkg::ENTRY_WIDTH-1:0]    entry0,
   output logic [erm_pkg::ENTRY_WIDTH-1:0]    entry1,
   output logic [erm_pkg::ENTRY_WIDTH-1:0]    entry2,
   output logic [erm_pkg::ENTRY_WIDTH-1:0]    entry4,
   output logic [erm_pkg::ENTRY_WIDTH-1:0]    entry5,
   output logic [erm_pkg::ENTRY_WIDTH-1:0]    entry6,
   output logic [erm_pkg::ENTRY_WIDTH-1:0]    entry8,
   output logic [erm_pkg::ENTRY_WIDTH-1:0]    entry9,
   output logic [erm_pkg::ENTRY_WIDTH-1:0]    entry10
);
   import erm_pkg::*;

   localparam int unsigned VAL_W  = FRAC_BITS + 2;
   localparam int unsigned PROD_W = 2 * VAL_W;
   localparam int unsigned SUM_W  = FRAC_BITS + 3;

   typedef logic signed [VAL_W-1:0] val_type;
   typedef logic [ENTRY_WIDTH-1:0]  entry_type;

   // Product rounded half up to FRAC_BITS
   function automatic val_type round_prod(input val_type a, input val_type b);
      logic signed [PROD_W-1:0] prod;
      prod = a * b + $signed(PROD_W'(1) << (FRAC_BITS - 1));
      return VAL_W'(prod >>> FRAC_BITS);
   endfunction

   // Clamp to +-1.0 and fold into the output field
   function automatic entry_type sat_entry(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] one;
      logic signed [SUM_W-1:0] clamped;
      logic signed [63:0]      wide;
      one = $signed(SUM_W'(1) << FRAC_BITS);
      priority if (v > one) begin
         clamped = one;
      end else if (v < -one) begin
         clamped = -one;
      end else begin
         clamped = v;
      end
      wide = 64'(clamped);
      return wide[ENTRY_WIDTH-1:0];
   endfunction

   // Stage C: pair products
   logic    c_valid_ff, c_valid_in;
   val_type c_czsy_ff, c_szsy_ff, c_czcy_ff, c_szcy_ff, c_szcx_ff;
   val_type c_szsx_ff, c_czcx_ff, c_czsx_ff, c_cysx_ff, c_cycx_ff;
   val_type c_sx_ff, c_cx_ff, c_sy_ff;
   // Stage D: triple products
   logic    d_valid_ff, d_valid_in;
   val_type d_t1_ff, d_t2_ff, d_t3_ff, d_t4_ff;
   val_type d_czcy_ff, d_szcy_ff, d_szcx_ff, d_szsx_ff, d_czcx_ff;
   val_type d_czsx_ff, d_cysx_ff, d_cycx_ff, d_sy_ff;
   // Stage E: output words
   logic      e_valid_ff, e_valid_in;
   entry_type e_entry_ff [9];
   entry_type e_entry_in [9];

   assign c_valid_in = in_valid;
   assign d_valid_in = c_valid_ff;
   assign e_valid_in = d_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= c_valid_in;
         d_valid_ff <= d_valid_in;
         e_valid_ff <= e_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      c_czsy_ff <= round_prod(cos_z, sin_y);
      c_szsy_ff <= round_prod(sin_z, sin_y);
      c_czcy_ff <= round_prod(cos_z, cos_y);
      c_szcy_ff <= round_prod(sin_z, cos_y);
      c_szcx_ff <= round_prod(sin_z, cos_x);
      c_szsx_ff <= round_prod(sin_z, sin_x);
      c_czcx_ff <= round_prod(cos_z, cos_x);
      c_czsx_ff <= round_prod(cos_z, sin_x);
      c_cysx_ff <= round_prod(cos_y, sin_x);
      c_cycx_ff <= round_prod(cos_y, cos_x);
      c_sx_ff   <= sin_x;
      c_cx_ff   <= cos_x;
      c_sy_ff   <= sin_y;
   end

   always_ff @(posedge clock) begin
      d_t1_ff   <= round_prod(c_czsy_ff, c_sx_ff);
      d_t2_ff   <= round_prod(c_czsy_ff, c_cx_ff);
      d_t3_ff   <= round_prod(c_szsy_ff, c_sx_ff);
      d_t4_ff   <= round_prod(c_szsy_ff, c_cx_ff);
      d_czcy_ff <= c_czcy_ff;
      d_szcy_ff <= c_szcy_ff;
      d_szcx_ff <= c_szcx_ff;
      d_szsx_ff <= c_szsx_ff;
      d_czcx_ff <= c_czcx_ff;
      d_czsx_ff <= c_czsx_ff;
      d_cysx_ff <= c_cysx_ff;
      d_cycx_ff <= c_cycx_ff;
      d_sy_ff   <= c_sy_ff;
   end

   always_comb begin
      e_entry_in[0] = sat_entry(SUM_W'(d_czcy_ff));
      e_entry_in[1] = sat_entry(SUM_W'(d_t1_ff) - SUM_W'(d_szcx_ff));
      e_entry_in[2] = sat_entry(SUM_W'(d_t2_ff) + SUM_W'(d_szsx_ff));
      e_entry_in[3] = sat_entry(SUM_W'(d_szcy_ff));
      e_entry_in[4] = sat_entry(SUM_W'(d_t3_ff) + SUM_W'(d_czcx_ff));
      e_entry_in[5] = sat_entry(SUM_W'(d_t4_ff) - SUM_W'(d_czsx_ff));
      e_entry_in[6] = sat_entry(-SUM_W'(d_sy_ff));
      e_entry_in[7] = sat_entry(SUM_W'(d_cysx_ff));
      e_entry_in[8] = sat_entry(SUM_W'(d_cycx_ff));
   end

   always_ff @(posedge clock) begin
      e_entry_ff <= e_entry_in;
   end

   assign out_valid = e_valid_ff;
   assign entry0    = e_entry_ff[0];
   assign entry1    = e_entry_ff[1];
   assign entry2    = e_entry_ff[2];
   assign entry4    = e_entry_ff[3];
   assign entry5    = e_entry_ff[4];
   assign entry6    = e_entry_ff[5];
   assign entry8    = e_entry_ff[6];
   assign entry9    = e_entry_ff[7];
   assign entry10   = e_entry_ff[8];

endmodule

`default_nettype wire

@@ design/euler_rotation_matrix_unit.sv @@
// ============================================================================
// euler_rotation_matrix_unit
// XYZ Euler rotation matrix entries from three binary angles.
// ============================================================================
// Usage:
//   Drive req_angle_x/y/z and raise start; the word is taken at a rising edge
//   where start is high and busy is low. Angles are unsigned binary angles,
//   2^ANGLE_BITS steps per turn; each is negated modulo a full turn before
//   the sine and cosine lookup.
//   The nine variable matrix entries come back on rsp_entry* as signed
//   Q1.FRAC_BITS words, rounded per product and clamped to +-1.0, marked by
//   rsp_valid for exactly one cycle. There is no back-pressure: take the
//   word in the cycle it is shown.
//   Throughput: one word per cycle, set by a five-stage pipeline (table
//   read, sign fold, pair products, triple products, sum and clamp) with
//   a dual-read sine table per axis.
//   Reset: synchronous, active high. All valid bits clear and busy is high
//   for the reset cycles; busy drops in the cycle after reset is released and
//   stays low from then on.
// ============================================================================
`default_nettype none

module euler_rotation_matrix_unit #(
   parameter int unsigned ANGLE_BITS = erm_pkg::ANGLE_BITS_DEFAULT,
   parameter int unsigned FRAC_BITS  = erm_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [ANGLE_BITS-1:0]           req_angle_x,
   input  logic [ANGLE_BITS-1:0]           req_angle_y,
   input  logic [ANGLE_BITS-1:0]           req_angle_z,
   output logic                            rsp_valid,
   output logic [erm_pkg::ENTRY_WIDTH-1:0] rsp_entry0,
   output logic [erm_pkg::ENTRY_WIDTH-1:0] rsp_entry1,
   output logic [erm_pkg::ENTRY_WIDTH-1:0] rsp_entry2,
   output logic [erm_pkg::ENTRY_WIDTH-1:0] rsp_entry4,
   output logic [erm_pkg::ENTRY_WIDTH-1:0] rsp_entry5,
   output logic [erm_pkg::ENTRY_WIDTH-1:0] rsp_entry6,
   output logic [erm_pkg::ENTRY_WIDTH-1:0] rsp_entry8,
   output logic [erm_pkg::ENTRY_WIDTH-1:0] rsp_entry9,
   output logic [erm_pkg::ENTRY_WIDTH-1:0] rsp_entry10
);
   import erm_pkg::*;

   localparam int unsigned VAL_W = FRAC_BITS + 2;

   logic                    busy_ff, busy_in;
   logic                    req_accept;
   logic                    trig_valid;
   logic signed [VAL_W-1:0] sin_x, cos_x, sin_y, cos_y, sin_z, cos_z;

   // Hold busy through reset, release it on the first cycle after
   assign busy_in = reset;

   always_ff @(posedge clock) begin
      busy_ff <= busy_in;
   end

   assign busy       = busy_ff;
   assign req_accept = start && !busy_ff;

   // Table lookup and sign fold: two stages
   erm_trig #(
      .ANGLE_BITS (ANGLE_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_trig (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .angle_x   (req_angle_x),
      .angle_y   (req_angle_y),
      .angle_z   (req_angle_z),
      .out_valid (trig_valid),
      .sin_x     (sin_x),
      .cos_x     (cos_x),
      .sin_y     (sin_y),
      .cos_y     (cos_y),
      .sin_z     (sin_z),
      .cos_z     (cos_z)
   );

   // Products, sums and clamp: three stages, last one drives the result port
   erm_combine #(
      .FRAC_BITS (FRAC_BITS)
   ) u_combine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (trig_valid),
      .sin_x     (sin_x),
      .cos_x     (cos_x),
      .sin_y     (sin_y),
      .cos_y     (cos_y),
      .sin_z     (sin_z),
      .cos_z     (cos_z),
      .out_valid (rsp_valid),
      .entry0    (rsp_entry0),
      .entry1    (rsp_entry1),
      .entry2    (rsp_entry2),
      .entry4    (rsp_entry4),
      .entry5    (rsp_entry5),
      .entry6    (rsp_entry6),
      .entry8    (rsp_entry8),
      .entry9    (rsp_entry9),
      .entry10   (rsp_entry10)
   );

endmodule

`default_nettype wire

@@ design/erm_checker.sv @@
// ============================================================================
// erm_checker
// Port-level checks on latency, strobe origin, busy release and entry range.
// ============================================================================
`default_nettype none

module erm_checker #(
   parameter int unsigned FRAC_BITS = erm_pkg::FRAC_BITS_DEFAULT
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            rsp_valid,
   input logic [erm_pkg::ENTRY_WIDTH-1:0] rsp_entry0,
   input logic [erm_pkg::ENTRY_WIDTH-1:0] rsp_entry8
);
   import erm_pkg::*;

   // Every accepted word shows up after the fixed pipeline delay
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##5 rsp_valid)
      else $error("accepted word did not produce a result");

   // No result without a word accepted at the matching edge
   a_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 5))
      else $error("result strobe without an accepted word");

   // Busy drops right after reset and stays low
   a_busy: assert property (@(posedge clock)
      !reset |=> !busy)
      else $error("busy high outside reset");

   if (FRAC_BITS <= 14) begin : g_range
      localparam logic signed [ENTRY_WIDTH-1:0] ONE = ENTRY_WIDTH'(1 << FRAC_BITS);

      a_range: assert property (@(posedge clock) disable iff (reset)
         rsp_valid |-> ($signed(rsp_entry0) <= ONE && $signed(rsp_entry0) >= -ONE
                     && $signed(rsp_entry8) <= ONE && $signed(rsp_entry8) >= -ONE))
         else $error("matrix entry outside +-1.0");
   end

endmodule

bind euler_rotation_matrix_unit erm_checker #(
   .FRAC_BITS (FRAC_BITS)
) u_erm_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_valid  (rsp_valid),
   .rsp_entry0 (rsp_entry0),
   .rsp_entry8 (rsp_entry8)
);

`default_nettype wire
